>>> rtl/asf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asf_pkg
// Types, constants and step functions shared by the arrival steering force
// pipeline.
// ----------------------------------------------------------------------------
package asf_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic [30:0] FLOOR_LSB = 31'(((2 ** FRAC_BITS) + 9999) / 10000);

    localparam int SQ_W       = 66;
    localparam int RT_W       = 33;
    localparam int RM_W       = 35;
    localparam int DV_W       = 64;
    localparam int DN_W       = 33;
    localparam int Q_W        = 31;
    localparam int SQRT_STEPS = 33;
    localparam int DIV_STEPS  = 31;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [31:0] goal_z;
        logic [30:0]        slow_radius;
        logic [30:0]        top_speed;
        logic [30:0]        top_force;
    } agent_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               arrived;
    } steer_t;

    typedef struct packed {
        logic [2:0][32:0] off;
        logic [2:0][31:0] vel;
        logic [30:0]      radius;
        logic [30:0]      tspeed;
        logic [30:0]      tforce;
        logic [30:0]      speed;
        logic [32:0]      goal_len;
        logic [2:0][32:0] steer;
        logic             arrived;
        logic             near;
        logic             clip;
    } ctx_t;

    typedef struct packed {
        logic [SQ_W-1:0] val;
        logic [RM_W-1:0] rem;
        logic [RT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [DV_W-1:0] rem;
        logic [DN_W-1:0] den;
        logic [Q_W-1:0]  q;
    } dv_t;

    function automatic logic [32:0] mag33(logic [32:0] v);
        return v[32] ? 33'(-v) : v;
    endfunction

    function automatic logic [31:0] sat32(logic [32:0] v);
        logic [31:0] r;
        unique case (v[32:31])
            2'b01:   r = 32'h7fff_ffff;
            2'b10:   r = 32'h8000_0000;
            default: r = v[31:0];
        endcase
        return r;
    endfunction

    // one root bit per call
    function automatic sq_t sqrt_step(sq_t s);
        sq_t           r;
        logic [RM_W:0] t;
        logic [RM_W:0] trial;
        t       = {s.rem[RM_W-2:0], s.val[SQ_W-1 -: 2]};
        trial   = {1'b0, s.root, 2'b01};
        r.val   = s.val << 2;
        if (t >= trial)
        begin
            r.rem  = RM_W'(t - trial);
            r.root = {s.root[RT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = t[RM_W-1:0];
            r.root = {s.root[RT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // one quotient bit per call, bit k
    function automatic dv_t div_step(dv_t d, int unsigned k);
        dv_t             r;
        logic [DV_W-1:0] sh;
        r  = d;
        sh = DV_W'(d.den) << k;
        if (d.rem >= sh)
        begin
            r.rem  = d.rem - sh;
            r.q[k] = 1'b1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/arrival_steering_force.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arrival_steering_force
// Arrival steering force for one agent per transaction, signed Q16.16.
// ----------------------------------------------------------------------------
// Fully pipelined: one agent enters per clock unless stalled, and its force
// leaves through an output register; the depth is set by two 33-step square
// root pipelines (goal distance and steer length) and three 31-step divider
// pipelines (slowing speed, desired velocity, force clip), one bit per stage.
// A two-entry output buffer (output register plus skid register) lets the
// pipeline keep accepting while a result waits; the whole pipeline stalls
// only when both entries are full. Results leave in input order.
module arrival_steering_force
    import asf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   agent_valid,
    output logic        agent_ready,
    input  wire agent_t agent,
    output logic        steer_valid,
    input  wire logic   steer_ready,
    output steer_t      steer
);

    localparam int S_SUM1  = 2;
    localparam int S_DIST  = S_SUM1 + SQRT_STEPS + 1;
    localparam int S_SPD   = S_DIST + DIV_STEPS + 1;
    localparam int S_STEER = S_SPD + DIV_STEPS + 1;
    localparam int S_SQ2   = S_STEER + 1;
    localparam int S_SUM2  = S_SQ2 + 1;
    localparam int S_LEN   = S_SUM2 + SQRT_STEPS + 1;
    localparam int LAST    = S_LEN + DIV_STEPS;

    logic            en;
    logic            vld_reg [0:LAST];
    ctx_t            cx_reg  [0:LAST];
    ctx_t            cx_next [0:LAST];
    ctx_t            c_in;

    logic [SQ_W-1:0] sq1_reg [0:2];
    logic [SQ_W-1:0] sq2_reg [0:2];
    logic [SQ_W-1:0] sq1     [0:2];
    logic [SQ_W-1:0] sq2     [0:2];
    sq_t             sqa_reg [0:SQRT_STEPS];
    sq_t             sqb_reg [0:SQRT_STEPS];
    dv_t             d1_reg  [0:DIV_STEPS];
    dv_t             d2_reg  [0:2][0:DIV_STEPS];
    dv_t             d3_reg  [0:2][0:DIV_STEPS];
    logic [DV_W-1:0] p1;
    logic [DV_W-1:0] p2      [0:2];
    logic [DV_W-1:0] p3      [0:2];
    logic [32:0]     m1      [0:2];
    logic [32:0]     m2      [0:2];

    steer_t          res;
    logic            steer_valid_reg;
    logic            steer_valid_next;
    steer_t          steer_reg;
    steer_t          steer_next;
    logic            skid_valid_reg;
    logic            skid_valid_next;
    steer_t          skid_reg;
    logic            take;

    assign en          = !skid_valid_reg;
    assign agent_ready = en;

    always_comb
    begin
        c_in        = '0;
        c_in.off[0] = {agent.goal_x[31], agent.goal_x} - {agent.pos_x[31], agent.pos_x};
        c_in.off[1] = {agent.goal_y[31], agent.goal_y} - {agent.pos_y[31], agent.pos_y};
        c_in.off[2] = {agent.goal_z[31], agent.goal_z} - {agent.pos_z[31], agent.pos_z};
        c_in.vel[0] = agent.vel_x;
        c_in.vel[1] = agent.vel_y;
        c_in.vel[2] = agent.vel_z;
        c_in.radius = (agent.slow_radius < FLOOR_LSB) ? FLOOR_LSB : agent.slow_radius;
        c_in.tspeed = agent.top_speed;
        c_in.tforce = agent.top_force;
    end

    always_comb
    begin
        logic [32:0] desired;
        cx_next[0] = c_in;
        for (int i = 1; i <= LAST; i++)
        begin
            cx_next[i] = cx_reg[i-1];
        end
        cx_next[S_DIST].goal_len = sqa_reg[SQRT_STEPS].root;
        cx_next[S_DIST].arrived  = sqa_reg[SQRT_STEPS].root <= {2'b00, FLOOR_LSB};
        cx_next[S_DIST].near     = sqa_reg[SQRT_STEPS].root < {2'b00, cx_reg[S_DIST-1].radius};
        cx_next[S_SPD].speed    = cx_reg[S_SPD-1].near ? d1_reg[DIV_STEPS].q
                                                       : cx_reg[S_SPD-1].tspeed;
        for (int l = 0; l < 3; l++)
        begin
            desired = cx_reg[S_STEER-1].off[l][32] ? 33'(-{2'b00, d2_reg[l][DIV_STEPS].q})
                                                   : {2'b00, d2_reg[l][DIV_STEPS].q};
            cx_next[S_STEER].steer[l] = desired - {cx_reg[S_STEER-1].vel[l][31],
                                                   cx_reg[S_STEER-1].vel[l]};
        end
        cx_next[S_LEN].clip = sqb_reg[SQRT_STEPS].root > {2'b00, cx_reg[S_LEN-1].tforce};
    end

    always_comb
    begin
        p1 = DV_W'(cx_reg[S_DIST-1].tspeed) * DV_W'(sqa_reg[SQRT_STEPS].root[30:0]);
        for (int l = 0; l < 3; l++)
        begin
            m1[l]  = mag33(cx_reg[0].off[l]);
            m2[l]  = mag33(cx_reg[S_SQ2-1].steer[l]);
            sq1[l] = SQ_W'(m1[l]) * SQ_W'(m1[l]);
            sq2[l] = SQ_W'(m2[l]) * SQ_W'(m2[l]);
            p2[l]  = DV_W'(mag33(cx_reg[S_SPD-1].off[l])) * DV_W'(cx_next[S_SPD].speed);
            p3[l]  = DV_W'(mag33(cx_reg[S_LEN-1].steer[l])) * DV_W'(cx_reg[S_LEN-1].tforce);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= agent_valid;
            for (int i = 1; i <= LAST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                cx_reg[i] <= cx_next[i];
            end
            for (int l = 0; l < 3; l++)
            begin
                sq1_reg[l] <= sq1[l];
                sq2_reg[l] <= sq2[l];
            end
            sqa_reg[0].val  <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
            sqa_reg[0].rem  <= '0;
            sqa_reg[0].root <= '0;
            sqb_reg[0].val  <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            sqb_reg[0].rem  <= '0;
            sqb_reg[0].root <= '0;
            for (int k = 1; k <= SQRT_STEPS; k++)
            begin
                sqa_reg[k] <= sqrt_step(sqa_reg[k-1]);
                sqb_reg[k] <= sqrt_step(sqb_reg[k-1]);
            end
            d1_reg[0].rem <= p1;
            d1_reg[0].den <= DN_W'(cx_reg[S_DIST-1].radius);
            d1_reg[0].q   <= '0;
            for (int j = 1; j <= DIV_STEPS; j++)
            begin
                d1_reg[j] <= div_step(d1_reg[j-1], Q_W - j);
            end
            for (int l = 0; l < 3; l++)
            begin
                d2_reg[l][0].rem <= p2[l];
                d2_reg[l][0].den <= cx_reg[S_SPD-1].goal_len;
                d2_reg[l][0].q   <= '0;
                d3_reg[l][0].rem <= p3[l];
                d3_reg[l][0].den <= sqb_reg[SQRT_STEPS].root;
                d3_reg[l][0].q   <= '0;
                for (int j = 1; j <= DIV_STEPS; j++)
                begin
                    d2_reg[l][j] <= div_step(d2_reg[l][j-1], Q_W - j);
                    d3_reg[l][j] <= div_step(d3_reg[l][j-1], Q_W - j);
                end
            end
        end
    end

    // final clip, saturation and arrival override
    always_comb
    begin
        logic [32:0] c    [0:2];
        logic [31:0] f    [0:2];
        logic [32:0] qext;
        for (int l = 0; l < 3; l++)
        begin
            qext = {2'b00, d3_reg[l][DIV_STEPS].q};
            if (cx_reg[LAST].clip)
            begin
                c[l] = cx_reg[LAST].steer[l][32] ? 33'(-qext) : qext;
            end
            else
            begin
                c[l] = cx_reg[LAST].steer[l];
            end
            f[l] = cx_reg[LAST].arrived ? 32'h0 : sat32(c[l]);
        end
        res.force_x = f[0];
        res.force_y = f[1];
        res.force_z = f[2];
        res.arrived = cx_reg[LAST].arrived;
    end

    // output register with skid entry
    assign take = steer_valid_reg && steer_ready;

    always_comb
    begin
        steer_valid_next = steer_valid_reg;
        steer_next       = steer_reg;
        skid_valid_next  = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                steer_next      = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!steer_valid_reg || take)
        begin
            steer_valid_next = vld_reg[LAST];
            steer_next       = res;
        end
        else if (vld_reg[LAST])
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steer_valid_reg <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            steer_valid_reg <= steer_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steer_reg <= steer_next;
        if (!skid_valid_reg)
        begin
            skid_reg <= res;
        end
    end

    assign steer_valid = steer_valid_reg;
    assign steer       = steer_reg;

`ifndef ASSERT_OFF
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> steer_valid_reg)
        else $error("skid entry held without output entry");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg[LAST]))
        else $error("pipeline moved while stalled");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(steer_valid_reg && !steer_ready))
        else $error("skid entry filled while output was free");

    a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (steer_valid && steer.arrived) |->
            (steer.force_x == 32'sd0 && steer.force_y == 32'sd0 && steer.force_z == 32'sd0))
        else $error("nonzero force on arrival");
`endif

endmodule
`default_nettype wire
